// ===== design/kst_pkg.sv =====
// kst_pkg: shared types, result codes and key map tables of the scancode translator
// used by kst_front, kst_fifo, kst_back and keyboard_scancode_translator
`timescale 1ns / 1ps

package kst_pkg;

	localparam logic [1:0] KIND_CHAR  = 2'd0;
	localparam logic [1:0] KIND_LED   = 2'd1;
	localparam logic [1:0] KIND_CON   = 2'd2;
	localparam logic [1:0] KIND_RESET = 2'd3;

	localparam int PLAIN_LEN = 79;
	localparam int UPPER_LEN = 98;
	localparam int PAD_LEN   = 13;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
	} kst_res_t;

	typedef struct packed {
		logic [1:0]         last_idx;
		kst_res_t [3:0]     res;
	} kst_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} kst_qstat_t;

	localparam logic [7:0] PLAIN_ROM [PLAIN_LEN] = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h7F, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
		8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
		8'h00, 8'h20, 8'h10, 8'h01, 8'h00, 8'h2D, 8'h00, 8'h00,
		8'h00, 8'h2B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h3C, 8'h2D, 8'h01, 8'h00, 8'h00, 8'h2B
	};

	localparam logic [7:0] UPPER_ROM [UPPER_LEN] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
		8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h7F, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
		8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
		8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3E, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00
	};

	localparam logic [7:0] PAD_DIGIT_ROM [PAD_LEN] = '{
		8'h37, 8'h38, 8'h39, 8'h20, 8'h34, 8'h35, 8'h36, 8'h20,
		8'h31, 8'h32, 8'h33, 8'h30, 8'h2E
	};

	localparam logic [7:0] PAD_MOVE_ROM [PAD_LEN] = '{
		8'h48, 8'h41, 8'h35, 8'h20, 8'h44, 8'h47, 8'h43, 8'h20,
		8'h59, 8'h42, 8'h36, 8'h32, 8'h33
	};

	function automatic logic [7:0] plain_read(input logic [7:0] code);
		logic [7:0] ch;
		ch = 8'h00;
		if (code < 8'(PLAIN_LEN))
			ch = PLAIN_ROM[code[6:0]];
		return ch;
	endfunction

	function automatic logic [7:0] upper_read(input logic [7:0] code);
		logic [7:0] ch;
		ch = 8'h00;
		if (code < 8'(UPPER_LEN))
			ch = UPPER_ROM[code[6:0]];
		return ch;
	endfunction

	function automatic logic [7:0] altgr_read(input logic [7:0] code);
		logic [7:0] ch;
		case (code)
			8'd3:    ch = 8'h40;
			8'd5:    ch = 8'h24;
			8'd8:    ch = 8'h7B;
			8'd9:    ch = 8'h5B;
			8'd10:   ch = 8'h5D;
			8'd11:   ch = 8'h7D;
			8'd12:   ch = 8'h5C;
			8'd27:   ch = 8'h7E;
			8'd28:   ch = 8'h0A;
			8'd58:   ch = 8'h10;
			8'd59:   ch = 8'h01;
			8'd73:   ch = 8'h7C;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// ===== design/keyboard_scancode_translator.sv =====
// keyboard_scancode_translator: set-1 scancode to character, led, console and reset events
// depends on kst_pkg, kst_front, kst_fifo, kst_back
//
// input channel: one scancode byte per transfer on scan_byte (in_valid / in_stall)
// output channel: one result per transfer on kind, value, last (out_valid / out_stall)
// a scancode gives zero to four results; last marks the final one of each scancode
// prefix bytes, shift, ctrl and alt codes, caps breaks and unmapped keys give no result
// the front takes a byte every cycle while the two-entry job queue has room
// with the queue empty and the back end idle, the first result of a byte is written
// into the job queue and then into the back end's job register, and the remaining
// results follow; throughput is set by the output side: one result per cycle while
// out_stall is low, at most four per byte; a byte without results never enters the queue
// when the receiver stalls, the current result holds, the queue fills and
// in_stall rises once both queue entries are taken
// reset clears modifiers and prefix, sets the num lock led and empties the queue
`timescale 1ns / 1ps

module keyboard_scancode_translator import kst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] scan_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] value,
	output logic       last
);

	kst_qstat_t qstat;
	kst_job_t   job_in;
	kst_job_t   job_out;
	logic       push;
	logic       pop;

	kst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.scan_byte (scan_byte),
		.qstat     (qstat),
		.push      (push),
		.job       (job_in)
	);

	kst_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.job_in  (job_in),
		.pop     (pop),
		.job_out (job_out),
		.qstat   (qstat)
	);

	kst_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_out),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.value     (value),
		.last      (last)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("job queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("job queue read while empty");

	a_drain_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last && !out_stall && qstat.empty) |=> !out_valid)
		else $error("result sent with no job pending");

	a_prefix_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (scan_byte == 8'hE0 || scan_byte == 8'hE1)) |-> !push)
		else $error("prefix byte produced a result job");

endmodule

// ===== design/kst_front.sv =====
// kst_front: takes scancode transfers, tracks modifiers, leds and prefix, builds result jobs
// depends on kst_pkg
`timescale 1ns / 1ps

module kst_front import kst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  scan_byte,
	input  kst_qstat_t  qstat,
	output logic        push,
	output kst_job_t    job
);

	typedef enum logic [2:0] {
		PFX_NONE = 3'b001,
		PFX_E0   = 3'b010,
		PFX_E1   = 3'b100
	} pfx_t;

	localparam logic [7:0] SC_E0      = 8'hE0;
	localparam logic [7:0] SC_E1      = 8'hE1;
	localparam logic [7:0] SC_DEL     = 8'h53;
	localparam logic [7:0] SC_SLASH   = 8'h35;
	localparam logic [7:0] SC_PAD_LO  = 8'h47;
	localparam logic [7:0] SC_F1      = 8'h3B;
	localparam logic [7:0] SC_F10     = 8'h44;
	localparam logic [7:0] SC_CTRL    = 8'h1D;
	localparam logic [7:0] SC_CTRL_BR = 8'h9D;
	localparam logic [7:0] SC_ALT     = 8'h38;
	localparam logic [7:0] SC_ALT_BR  = 8'hB8;
	localparam logic [7:0] SC_LSH     = 8'h2A;
	localparam logic [7:0] SC_LSH_BR  = 8'hAA;
	localparam logic [7:0] SC_RSH     = 8'h36;
	localparam logic [7:0] SC_RSH_BR  = 8'hB6;
	localparam logic [7:0] SC_CAPS    = 8'h3A;
	localparam logic [7:0] SC_CAPS_BR = 8'hBA;
	localparam logic [7:0] SC_NUM     = 8'h45;
	localparam logic [7:0] SC_SCROLL  = 8'h46;
	localparam logic [7:0] CH_ESC     = 8'h1B;
	localparam logic [7:0] CH_BRACKET = 8'h5B;
	localparam logic [7:0] CH_TILDE   = 8'h7E;
	localparam logic [7:0] CH_SLASH   = 8'h2F;

	logic [7:0] mod_q, mod_d;
	logic [2:0] led_q, led_d;
	pfx_t       pfx_q, pfx_d;

	logic       accept;
	logic       pre;
	logic       rst_req;
	logic       is_plain;
	logic [7:0] pk_ch;
	logic       pk_ok;
	logic [7:0] pad_off;
	logic [3:0] pad_i;
	logic [7:0] mv_ch;
	logic [7:0] con_off;
	kst_res_t   body [3];
	logic [1:0] body_n;
	logic [2:0] total;

	assign in_stall = qstat.full;
	assign accept   = in_valid && !in_stall;
	assign pre      = (pfx_q != PFX_NONE);
	assign rst_req  = (scan_byte == SC_DEL) && mod_q[2] && mod_q[4];

	assign is_plain = (scan_byte >= 8'h01 && scan_byte <= 8'h1C)
		|| (scan_byte >= 8'h1E && scan_byte <= 8'h29)
		|| (scan_byte >= 8'h2B && scan_byte <= 8'h34)
		|| scan_byte == 8'h37 || scan_byte == 8'h39 || scan_byte == 8'h4A
		|| scan_byte == 8'h4E || scan_byte == 8'h56;

	// table lookup plus caps, ctrl and left alt rules
	always_comb begin
		if (mod_q[5])
			pk_ch = altgr_read(scan_byte);
		else if (|mod_q[1:0])
			pk_ch = upper_read(scan_byte);
		else
			pk_ch = plain_read(scan_byte);
		pk_ok = (pk_ch != 8'h00);
		if (mod_q[6] || mod_q[3] || mod_q[2]) begin
			if (mod_q[6] && (|mod_q[1:0])) begin
				if (pk_ch >= 8'h41 && pk_ch <= 8'h5A)
					pk_ch = pk_ch + 8'h20;
			end else if (pk_ch >= 8'h61 && pk_ch <= 8'h7A) begin
				pk_ch = pk_ch - 8'h20;
			end
			if (|mod_q[3:2])
				pk_ch = pk_ch - 8'h40;
		end
		if (mod_q[4])
			pk_ch = pk_ch | 8'h80;
	end

	assign pad_off = scan_byte - SC_PAD_LO;
	assign pad_i   = pad_off[3:0];
	assign con_off = scan_byte - SC_F1;

	always_comb begin
		mv_ch = PAD_MOVE_ROM[pad_i];
		if (mv_ch <= 8'h39)
			mv_ch = CH_TILDE;
	end

	always_comb begin
		mod_d  = mod_q;
		led_d  = led_q;
		pfx_d  = pfx_q;
		body_n = 2'd0;
		for (int k = 0; k < 3; k++)
			body[k] = '{kind: KIND_CHAR, value: 8'h00};
		if (scan_byte == SC_E0) begin
			pfx_d = PFX_E0;
		end else if (scan_byte == SC_E1) begin
			pfx_d = PFX_E1;
		end else begin
			pfx_d = PFX_NONE;
			if (is_plain) begin
				body[0] = '{kind: KIND_CHAR, value: pk_ch};
				body_n  = {1'b0, pk_ok};
			end else if (scan_byte == SC_SLASH) begin
				if (pfx_q == PFX_E0) begin
					body[0] = '{kind: KIND_CHAR, value: CH_SLASH};
					body_n  = 2'd1;
				end else begin
					body[0] = '{kind: KIND_CHAR, value: pk_ch};
					body_n  = {1'b0, pk_ok};
				end
			end else if (scan_byte >= SC_PAD_LO && scan_byte <= SC_DEL) begin
				if (pfx_q == PFX_E0 || !led_q[1] || (|mod_q[1:0])) begin
					body[0] = '{kind: KIND_CHAR, value: CH_ESC};
					body[1] = '{kind: KIND_CHAR, value: CH_BRACKET};
					body[2] = '{kind: KIND_CHAR, value: mv_ch};
					body_n  = 2'd3;
				end else begin
					body[0] = '{kind: KIND_CHAR, value: PAD_DIGIT_ROM[pad_i]};
					body_n  = 2'd1;
				end
			end else if (scan_byte >= SC_F1 && scan_byte <= SC_F10) begin
				body[0] = '{kind: KIND_CON, value: {6'd0, con_off[1:0]}};
				body_n  = 2'd1;
			end else begin
				case (scan_byte)
					SC_CTRL:    mod_d = pre ? (mod_q | 8'h08) : (mod_q | 8'h04);
					SC_CTRL_BR: mod_d = pre ? (mod_q & 8'hF7) : (mod_q & 8'hFB);
					SC_ALT:     mod_d = pre ? (mod_q | 8'h20) : (mod_q | 8'h10);
					SC_ALT_BR:  mod_d = pre ? (mod_q & 8'hDF) : (mod_q & 8'hEF);
					SC_LSH:     mod_d = mod_q | 8'h01;
					SC_LSH_BR:  mod_d = mod_q & 8'hFE;
					SC_RSH:     mod_d = mod_q | 8'h02;
					SC_RSH_BR:  mod_d = mod_q & 8'hFD;
					SC_CAPS: begin
						if (!mod_q[7]) begin
							led_d   = led_q ^ 3'b100;
							mod_d   = (mod_q ^ 8'h40) | 8'h80;
							body[0] = '{kind: KIND_LED, value: {5'd0, led_q ^ 3'b100}};
							body_n  = 2'd1;
						end
					end
					SC_CAPS_BR: mod_d = mod_q & 8'h7F;
					SC_NUM: begin
						led_d   = led_q ^ 3'b010;
						body[0] = '{kind: KIND_LED, value: {5'd0, led_q ^ 3'b010}};
						body_n  = 2'd1;
					end
					SC_SCROLL: begin
						led_d   = led_q ^ 3'b001;
						body[0] = '{kind: KIND_LED, value: {5'd0, led_q ^ 3'b001}};
						body_n  = 2'd1;
					end
					default: ;
				endcase
			end
		end
	end

	// reset request goes ahead of whatever the key itself gives
	always_comb begin
		job.res = '0;
		if (rst_req) begin
			job.res[0] = '{kind: KIND_RESET, value: 8'h00};
			for (int k = 0; k < 3; k++)
				job.res[k + 1] = body[k];
		end else begin
			for (int k = 0; k < 3; k++)
				job.res[k] = body[k];
		end
		total        = {1'b0, body_n} + {2'd0, rst_req};
		job.last_idx = 2'(total - 3'd1);
	end

	assign push = accept && (total != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= 8'h00;
			led_q <= 3'b010;
			pfx_q <= PFX_NONE;
		end else if (accept) begin
			mod_q <= mod_d;
			led_q <= led_d;
			pfx_q <= pfx_d;
		end
	end

endmodule

// ===== design/kst_fifo.sv =====
// kst_fifo: two-entry job queue between the front and back of the translator
// depends on kst_pkg
`timescale 1ns / 1ps

module kst_fifo import kst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  kst_job_t   job_in,
	input  logic       pop,
	output kst_job_t   job_out,
	output kst_qstat_t qstat
);

	kst_job_t   mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign qstat.full  = (cnt_q == 2'd2);
	assign qstat.empty = (cnt_q == 2'd0);
	assign job_out     = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= job_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== design/kst_back.sv =====
// kst_back: sends queued jobs' results, one per cycle while out_stall is low
// depends on kst_pkg
`timescale 1ns / 1ps

module kst_back import kst_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  kst_job_t   job,
	input  kst_qstat_t qstat,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] value,
	output logic       last
);

	kst_job_t   cur_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       done;
	kst_res_t   sel;

	assign done = busy_q && !out_stall && (idx_q == cur_q.last_idx);
	assign pop  = !qstat.empty && (!busy_q || done);

	assign sel       = cur_q.res[idx_q];
	assign out_valid = busy_q;
	assign kind      = sel.kind;
	assign value     = sel.value;
	assign last      = (idx_q == cur_q.last_idx);

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q && !out_stall) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

// ===== tb/keyboard_scancode_translator_test.sv =====
// keyboard_scancode_translator_test: self-checking testbench of the set-1 scancode translator
// holds its own key map tables, an event scoreboard class and the drive tasks; needs kst_pkg
`timescale 1ns / 1ps

import kst_pkg::*;

typedef struct {
	logic [1:0] kind;
	logic [7:0] value;
	logic       last;
} key_event_t;

typedef enum logic [1:0] {PFX_NONE, PFX_E0, PFX_E1} prefix_t;

localparam logic [7:0] SC_PREFIX_E0 = 8'hE0;
localparam logic [7:0] SC_PREFIX_E1 = 8'hE1;
localparam logic [7:0] SC_BREAK     = 8'h80;
localparam logic [7:0] SC_LCTRL     = 8'h1D;
localparam logic [7:0] SC_LALT      = 8'h38;
localparam logic [7:0] SC_LSHIFT    = 8'h2A;
localparam logic [7:0] SC_RSHIFT    = 8'h36;
localparam logic [7:0] SC_CAPS      = 8'h3A;
localparam logic [7:0] SC_NUMLOCK   = 8'h45;
localparam logic [7:0] SC_SCROLL    = 8'h46;
localparam logic [7:0] SC_DEL       = 8'h53;
localparam logic [7:0] SC_SLASH     = 8'h35;
localparam logic [7:0] SC_PAD_FIRST = 8'h47;
localparam logic [7:0] SC_F1        = 8'h3B;
localparam logic [7:0] SC_F10       = 8'h44;

localparam int MOD_LSHIFT = 0;
localparam int MOD_RSHIFT = 1;
localparam int MOD_LCTRL  = 2;
localparam int MOD_RCTRL  = 3;
localparam int MOD_LALT   = 4;
localparam int MOD_RALT   = 5;
localparam int MOD_CAPS   = 6;
localparam int MOD_CAPS_HELD = 7;

localparam int LED_SCROLL = 0;
localparam int LED_NUM    = 1;
localparam int LED_CAPS   = 2;

localparam logic [7:0] ASCII_ESC = 8'h1B;

localparam logic [7:0] KEY_LOWER [79] = '{
	8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
	8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h7F, 8'h09,
	8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
	8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
	8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
	8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
	8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
	8'h00, 8'h20, 8'h10, 8'h01, 8'h00, 8'h2D, 8'h00, 8'h00,
	8'h00, 8'h2B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
	8'h00, 8'h3C, 8'h2D, 8'h01, 8'h00, 8'h00, 8'h2B
};

localparam logic [7:0] KEY_UPPER [98] = '{
	8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
	8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h7F, 8'h09,
	8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
	8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
	8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
	8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
	8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
	8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
	8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
	8'h00, 8'h00, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h2B, 8'h00,
	8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h3E, 8'h00,
	8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
	8'h00, 8'h00
};

localparam logic [7:0] KEY_ALTGR [84] = '{
	8'h00, 8'h00, 8'h00, 8'h40, 8'h00, 8'h24, 8'h00, 8'h00, 8'h7B, 8'h5B, 8'h5D, 8'h7D,
	8'h5C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
	8'h00, 8'h00, 8'h00, 8'h7E, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
	8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
	8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h10, 8'h01,
	8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
	8'h00, 8'h7C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
};

localparam logic [7:0] PAD_NUM [13] = '{
	8'h37, 8'h38, 8'h39, 8'h20, 8'h34, 8'h35, 8'h36, 8'h20,
	8'h31, 8'h32, 8'h33, 8'h30, 8'h2E
};

localparam logic [7:0] PAD_CURSOR [13] = '{
	8'h48, 8'h41, 8'h35, 8'h20, 8'h44, 8'h47, 8'h43, 8'h20,
	8'h59, 8'h42, 8'h36, 8'h32, 8'h33
};

class key_event_board;
	key_event_t pending[$];
	key_event_t fresh[$];
	logic [7:0] mods;
	logic [2:0] leds;
	prefix_t    prefix;
	int         failures;

	function new();
		mods = 8'h00;
		leds = 3'd2;
		prefix = PFX_NONE;
		failures = 0;
	endfunction

	function void add(logic [1:0] k, logic [7:0] v);
		key_event_t e;
		e.kind = k;
		e.value = v;
		e.last = 1'b0;
		fresh.push_back(e);
	endfunction

	function void char_key(logic [7:0] code);
		logic [7:0] ch;
		if (mods[MOD_RALT])
			ch = (code < 8'd84) ? KEY_ALTGR[code] : 8'h00;
		else if (mods[MOD_LSHIFT] || mods[MOD_RSHIFT])
			ch = (code < 8'd98) ? KEY_UPPER[code] : 8'h00;
		else
			ch = (code < 8'd79) ? KEY_LOWER[code] : 8'h00;
		if (ch == 8'h00)
			return;
		if (mods[MOD_CAPS] || mods[MOD_LCTRL] || mods[MOD_RCTRL]) begin
			if (mods[MOD_CAPS] && (mods[MOD_LSHIFT] || mods[MOD_RSHIFT])) begin
				if (ch >= "A" && ch <= "Z")
					ch = ch + 8'h20;
			end else if (ch >= "a" && ch <= "z") begin
				ch = ch - 8'h20;
			end
			// ctrl wraps below zero
			if (mods[MOD_LCTRL] || mods[MOD_RCTRL])
				ch = ch - 8'h40;
		end
		if (mods[MOD_LALT])
			ch[7] = 1'b1;
		add(KIND_CHAR, ch);
	endfunction

	function void note_scancode(logic [7:0] code);
		logic       pre;
		logic [7:0] idx;
		logic [7:0] ch;
		pre = (prefix != PFX_NONE);
		fresh.delete();
		if (code == SC_DEL && mods[MOD_LCTRL] && mods[MOD_LALT])
			add(KIND_RESET, 8'h00);
		if (code == SC_PREFIX_E0) begin
			prefix = PFX_E0;
		end else if (code == SC_PREFIX_E1) begin
			prefix = PFX_E1;
		end else begin
			if ((code >= 8'h01 && code <= 8'h1C) || (code >= 8'h1E && code <= 8'h29) ||
					(code >= 8'h2B && code <= 8'h34) || code == 8'h37 || code == 8'h39 ||
					code == 8'h4A || code == 8'h4E || code == 8'h56) begin
				char_key(code);
			end else if (code == SC_SLASH) begin
				if (prefix == PFX_E0)
					add(KIND_CHAR, "/");
				else
					char_key(code);
			end else if (code >= SC_PAD_FIRST && code <= SC_DEL) begin
				idx = code - SC_PAD_FIRST;
				if (prefix == PFX_E0 || !leds[LED_NUM] || mods[MOD_LSHIFT] || mods[MOD_RSHIFT]) begin
					ch = PAD_CURSOR[idx];
					if (ch <= "9")
						ch = "~";
					add(KIND_CHAR, ASCII_ESC);
					add(KIND_CHAR, "[");
					add(KIND_CHAR, ch);
				end else begin
					add(KIND_CHAR, PAD_NUM[idx]);
				end
			end else if (code >= SC_F1 && code <= SC_F10) begin
				idx = code - SC_F1;
				add(KIND_CON, {6'd0, idx[1:0]});
			end else begin
				case (code)
					SC_LCTRL:              if (pre) mods[MOD_RCTRL] = 1'b1; else mods[MOD_LCTRL] = 1'b1;
					SC_LCTRL | SC_BREAK:   if (pre) mods[MOD_RCTRL] = 1'b0; else mods[MOD_LCTRL] = 1'b0;
					SC_LALT:               if (pre) mods[MOD_RALT] = 1'b1; else mods[MOD_LALT] = 1'b1;
					SC_LALT | SC_BREAK:    if (pre) mods[MOD_RALT] = 1'b0; else mods[MOD_LALT] = 1'b0;
					SC_LSHIFT:             mods[MOD_LSHIFT] = 1'b1;
					SC_LSHIFT | SC_BREAK:  mods[MOD_LSHIFT] = 1'b0;
					SC_RSHIFT:             mods[MOD_RSHIFT] = 1'b1;
					SC_RSHIFT | SC_BREAK:  mods[MOD_RSHIFT] = 1'b0;
					SC_CAPS: begin
						// held caps key repeats without effect
						if (!mods[MOD_CAPS_HELD]) begin
							leds[LED_CAPS] = ~leds[LED_CAPS];
							mods[MOD_CAPS] = ~mods[MOD_CAPS];
							mods[MOD_CAPS_HELD] = 1'b1;
							add(KIND_LED, {5'd0, leds});
						end
					end
					SC_CAPS | SC_BREAK:    mods[MOD_CAPS_HELD] = 1'b0;
					SC_NUMLOCK: begin
						leds[LED_NUM] = ~leds[LED_NUM];
						add(KIND_LED, {5'd0, leds});
					end
					SC_SCROLL: begin
						leds[LED_SCROLL] = ~leds[LED_SCROLL];
						add(KIND_LED, {5'd0, leds});
					end
					default: ;
				endcase
			end
			prefix = PFX_NONE;
		end
		if (fresh.size() > 0)
			fresh[fresh.size() - 1].last = 1'b1;
		foreach (fresh[i])
			pending.push_back(fresh[i]);
	endfunction

	function void check_event(logic [1:0] k, logic [7:0] v, logic l);
		key_event_t e;
		if (pending.size() == 0) begin
			$error("unexpected result: kind %0d value %02h last %0d", k, v, l);
			failures++;
			return;
		end
		e = pending.pop_front();
		if (e.kind !== k) begin
			$error("kind mismatch: expected %0d, actual %0d", e.kind, k);
			failures++;
		end
		if (e.value !== v) begin
			$error("value mismatch: expected %02h, actual %02h", e.value, v);
			failures++;
		end
		if (e.last !== l) begin
			$error("last mismatch: expected %0d, actual %0d", e.last, l);
			failures++;
		end
	endfunction
endclass

module keyboard_scancode_translator_test;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic [7:0] scan_byte = 8'h00;
	logic       out_stall = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic [1:0] kind;
	logic [7:0] value;
	logic       last;

	key_event_board board = new();

	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   keys_sent = 0;
	logic hold_req = 1'b0;
	int   hold_count = 0;

	logic [7:0] opening_keys [$] = '{
		8'h1E, 8'hFF, 8'h01, 8'h2A, 8'h56, 8'h1D, 8'h03, 8'hAA, 8'h0B, 8'h38,
		8'h53, 8'h9D, 8'h1E, 8'hB8, 8'hE0, 8'h1D, 8'hE0, 8'h9D, 8'hE0, 8'h38,
		8'h08, 8'hE0, 8'hB8, 8'hE0, 8'h35, 8'h35, 8'hE0, 8'h48, 8'h52, 8'h45,
		8'h52, 8'h3A, 8'h3A, 8'hBA, 8'h10, 8'h3B, 8'h44, 8'h57, 8'h46, 8'hE1,
		8'h1D, 8'hE1, 8'h9D
	};

	keyboard_scancode_translator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.scan_byte (scan_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.value     (value),
		.last      (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("== FAIL ==");
		$finish;
	end

	// receiver: random stall, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_count = 80;
		end
		if (hold_count > 0) begin
			hold_count--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_event(kind, value, last);
			if (in_valid && !in_stall)
				board.note_scancode(scan_byte);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		scan_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		if (b != SC_PREFIX_E0 && b != SC_PREFIX_E1)
			keys_sent++;
	endtask

	task automatic send_random_key();
		logic [7:0] mod_keys [5] = '{SC_LCTRL, SC_LALT, SC_LSHIFT, SC_RSHIFT, SC_CAPS};
		logic [7:0] code;
		int         r;
		r = $urandom_range(99);
		if (r < 10) begin
			send_byte(8'($urandom_range(255)));
		end else if (r < 40) begin
			if ($urandom_range(9) == 0)
				send_byte(SC_PREFIX_E0);
			if ($urandom_range(9) == 0)
				send_byte(8'($urandom_range(8'h4A, 8'h58)));
			else
				send_byte(8'($urandom_range(8'h01, 8'h39)));
		end else if (r < 60) begin
			code = mod_keys[$urandom_range(4)];
			if ((code == SC_LCTRL || code == SC_LALT) && $urandom_range(1))
				send_byte($urandom_range(1) ? SC_PREFIX_E0 : SC_PREFIX_E1);
			if ($urandom_range(1))
				code = code | SC_BREAK;
			send_byte(code);
		end else if (r < 75) begin
			if ($urandom_range(2) == 0)
				send_byte(SC_PREFIX_E0);
			send_byte(8'($urandom_range(SC_PAD_FIRST, SC_DEL)));
		end else if (r < 82) begin
			send_byte($urandom_range(1) ? SC_NUMLOCK : SC_SCROLL);
		end else if (r < 92) begin
			send_byte(8'($urandom_range(SC_F1, 8'h58)));
		end else begin
			// three-finger salute, then release
			send_byte(SC_LCTRL);
			send_byte(SC_LALT);
			send_byte(SC_DEL);
			send_byte(SC_LCTRL | SC_BREAK);
			send_byte(SC_LALT | SC_BREAK);
		end
	endtask

	initial begin
		int waited;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 16;
		recv_idle_pct = 64;
		foreach (opening_keys[i])
			send_byte(opening_keys[i]);

		for (int phase = 0; phase < 3; phase++) begin
			keys_sent = 0;
			case (phase)
				0: begin send_idle_pct = 16; recv_idle_pct = 64; end
				1: begin send_idle_pct = 64; recv_idle_pct = 16; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; hold_req = 1'b1; end
			endcase
			while (keys_sent < 95)
				send_random_key();
		end
		in_valid <= 1'b0;

		waited = 0;
		while (board.pending.size() != 0 && waited < 20000) begin
			@(negedge clk);
			waited++;
		end
		repeat (16) @(negedge clk);
		if (board.pending.size() != 0) begin
			$error("%0d expected results never arrived", board.pending.size());
			board.failures++;
		end
		if (board.failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
